[hdl/sbc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and control/status types for the stereo bitcrusher.
// No dependencies; used by sbc_ctrl, sbc_dp and the top level.
package sbc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int IN_DATA_W  = 136;  // 129 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam int MIN_BITS  = 1;
  localparam int BITS_CEIL = 16;
  localparam int MIN_RATE  = 64;
  localparam int ONE_Q16   = 65536;

  localparam int DIV_STEPS = 17;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [4:0]  RST_MAX_BITS = 5'd8;
  localparam logic [16:0] RST_RATE     = 17'd16384;
  localparam logic [16:0] RST_CHAOS    = 17'd0;
  localparam logic [15:0] RST_GAIN     = 16'd4096;
  localparam logic [16:0] RST_WET      = 17'd32768;
  localparam logic [16:0] RST_PHASE    = 17'd65536;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_BITS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RATE     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CHAOS    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WET      = 3'd4;

  typedef struct packed {
    logic load;
    logic chaos_mul;
    logic draw;
    logic phase;
    logic q_mul;
    logic q_init;
    logic div_step;
    logic hold;
    logic mix1;
    logic mix2;
    logic mix3;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic capture;
  } sts_t;

endpackage

[hdl/sbc_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the bitcrusher: steps the datapath through one item and
// owns the input/output handshakes. Depends on sbc_pkg.
module sbc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  sbc_pkg::sts_t sts,
  output sbc_pkg::cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_CHAOS = 12'b0000_0000_0010,
    S_DRAW  = 12'b0000_0000_0100,
    S_PHASE = 12'b0000_0000_1000,
    S_QMUL  = 12'b0000_0001_0000,
    S_QNUM  = 12'b0000_0010_0000,
    S_DIV   = 12'b0000_0100_0000,
    S_HOLD  = 12'b0000_1000_0000,
    S_MIX1  = 12'b0001_0000_0000,
    S_MIX2  = 12'b0010_0000_0000,
    S_MIX3  = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  localparam logic [sbc_pkg::CNT_W-1:0] CNT_LAST = sbc_pkg::CNT_W'(sbc_pkg::DIV_STEPS - 1);

  state_t                    state, state_next;
  logic [sbc_pkg::CNT_W-1:0] cnt;
  logic                      out_valid;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_CHAOS;
        end
      end
      S_CHAOS: begin
        cmd.chaos_mul = 1'b1;
        state_next    = S_DRAW;
      end
      S_DRAW: begin
        cmd.draw   = 1'b1;
        state_next = S_PHASE;
      end
      S_PHASE: begin
        cmd.phase  = 1'b1;
        state_next = sts.capture ? S_QMUL : S_HOLD;
      end
      S_QMUL: begin
        cmd.q_mul  = 1'b1;
        state_next = S_QNUM;
      end
      S_QNUM: begin
        cmd.q_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        cmd.hold   = 1'b1;
        state_next = S_MIX1;
      end
      S_MIX1: begin
        cmd.mix1   = 1'b1;
        state_next = S_MIX2;
      end
      S_MIX2: begin
        cmd.mix2   = 1'b1;
        state_next = S_MIX3;
      end
      S_MIX3: begin
        cmd.mix3   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_tready))
    else $error("output register overwritten while held");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_CHAOS))
    else $error("accepted item did not start processing");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == CNT_LAST) |=> (state == S_HOLD))
    else $error("divider ran a wrong number of steps");

  a_out_done: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (out_valid && state == S_IDLE))
    else $error("result not presented after load");

endmodule

[hdl/sbc_dp.sv]
`timescale 1ns / 1ps
// Bitcrusher datapath: config registers, chaos draw, phase accumulator,
// two-lane quantizer with restoring divider, mix and saturation. Uses sbc_pkg.
module sbc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sbc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [sbc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [sbc_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                              s_tuser,
  output logic [sbc_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  sbc_pkg::cmd_t                     cmd,
  output sbc_pkg::sts_t                     sts
);

  // configuration
  logic [4:0]  max_bits;
  logic [16:0] cap_rate;
  logic [16:0] chaos;
  logic [15:0] gain;
  logic [16:0] wet;

  // persistent state
  logic [16:0] phase;
  logic [4:0]  cur_bits;
  logic [16:0] cur_rate;
  logic [15:0] held [2];

  // per-item working registers
  logic [15:0] dry [2];
  logic [15:0] acc [2];
  logic [16:0] ent;
  logic [15:0] pr, br, rr;
  logic [16:0] eff;
  logic        cap;
  logic [15:0] lvl;
  logic [31:0] qprod [2];
  logic [15:0] rem [2];
  logic [16:0] quo [2];
  logic signed [33:0] pd [2];
  logic signed [33:0] ph [2];
  logic signed [33:0] blend [2];
  logic signed [50:0] gprod [2];

  // combinational
  logic [16:0] one_m;
  logic [33:0] chaos_prod;
  logic [20:0] bprod;
  logic [31:0] rprod;
  logic [17:0] psum;
  logic [16:0] dw;
  logic [31:0] qsum [2];
  logic [31:0] num [2];
  logic [16:0] dtry [2];
  logic        dge [2];
  logic [50:0] rsum [2];
  logic signed [22:0] scaled [2];
  logic signed [23:0] tot [2];
  logic [15:0] res [2];
  logic [4:0]  wbits;
  logic [16:0] wrate, wq16;

  always_comb begin
    one_m      = (ent >= 17'(sbc_pkg::ONE_Q16)) ? 17'd0 : 17'(sbc_pkg::ONE_Q16) - ent;
    chaos_prod = {17'd0, chaos} * {17'd0, one_m};
    bprod      = 21'(br) * 21'(max_bits - 5'(sbc_pkg::MIN_BITS) + 5'd1);
    rprod      = 32'(rr) * 32'(cap_rate - 17'(sbc_pkg::MIN_RATE));
    psum       = {1'b0, phase} + {1'b0, cur_rate};
    sts.capture = (psum >= 18'(sbc_pkg::ONE_Q16));
    dw         = 17'(sbc_pkg::ONE_Q16) - wet;
    for (int i = 0; i < 2; i++) begin
      qsum[i]   = qprod[i] + 32'h0000_8000;
      num[i]    = {qsum[i][31:16], 16'd0} + {17'd0, lvl[15:1]};
      dtry[i]   = {rem[i], quo[i][16]};
      dge[i]    = (dtry[i] >= {1'b0, lvl});
      rsum[i]   = gprod[i] + 51'(28'h800_0000);
      scaled[i] = rsum[i][50:28];
      tot[i]    = 24'($signed(acc[i])) + 24'(scaled[i]);
      if (tot[i][23:15] == 9'h000 || tot[i][23:15] == 9'h1FF) begin
        res[i] = tot[i][15:0];
      end else begin
        res[i] = tot[i][23] ? 16'h8000 : 16'h7FFF;
      end
    end
    // write-side clamps
    if (cfg_wdata[4:0] < 5'(sbc_pkg::MIN_BITS)) begin
      wbits = 5'(sbc_pkg::MIN_BITS);
    end else if (cfg_wdata[4:0] > 5'(sbc_pkg::BITS_CEIL)) begin
      wbits = 5'(sbc_pkg::BITS_CEIL);
    end else begin
      wbits = cfg_wdata[4:0];
    end
    if (cfg_wdata < 17'(sbc_pkg::MIN_RATE)) begin
      wrate = 17'(sbc_pkg::MIN_RATE);
    end else if (cfg_wdata > 17'(sbc_pkg::ONE_Q16)) begin
      wrate = 17'(sbc_pkg::ONE_Q16);
    end else begin
      wrate = cfg_wdata;
    end
    wq16 = (cfg_wdata > 17'(sbc_pkg::ONE_Q16)) ? 17'(sbc_pkg::ONE_Q16) : cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bits <= sbc_pkg::RST_MAX_BITS;
      cap_rate <= sbc_pkg::RST_RATE;
      chaos    <= sbc_pkg::RST_CHAOS;
      gain     <= sbc_pkg::RST_GAIN;
      wet      <= sbc_pkg::RST_WET;
      phase    <= sbc_pkg::RST_PHASE;
      cur_bits <= sbc_pkg::RST_MAX_BITS;
      cur_rate <= sbc_pkg::RST_RATE;
      held[0]  <= '0;
      held[1]  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          sbc_pkg::REG_MAX_BITS: max_bits <= wbits;
          sbc_pkg::REG_RATE:     cap_rate <= wrate;
          sbc_pkg::REG_CHAOS:    chaos    <= wq16;
          sbc_pkg::REG_GAIN:     gain     <= cfg_wdata[15:0];
          sbc_pkg::REG_WET:      wet      <= wq16;
          default: ;
        endcase
      end
      if (cmd.load && s_tuser) begin
        cur_bits <= max_bits;
        cur_rate <= cap_rate;
      end
      if (cmd.draw && ({1'b0, pr} < eff)) begin
        cur_bits <= 5'(bprod[20:16]) + 5'(sbc_pkg::MIN_BITS);
        cur_rate <= {1'b0, rprod[31:16]} + 17'(sbc_pkg::MIN_RATE);
      end
      if (cmd.phase) begin
        phase <= sts.capture ? 17'(psum - 18'(sbc_pkg::ONE_Q16)) : psum[16:0];
      end
      if (cmd.hold) begin
        for (int i = 0; i < 2; i++) begin
          if (dry[i] == 16'd0) begin
            held[i] <= 16'd0;
          end else if (cap) begin
            held[i] <= quo[i][16] ? 16'h7FFF : {~quo[i][15], quo[i][14:0]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dry[0] <= s_tdata[15:0];
      dry[1] <= s_tdata[31:16];
      acc[0] <= s_tdata[47:32];
      acc[1] <= s_tdata[63:48];
      ent    <= s_tdata[80:64];
      pr     <= s_tdata[96:81];
      br     <= s_tdata[112:97];
      rr     <= s_tdata[128:113];
    end
    if (cmd.chaos_mul) begin
      eff <= chaos_prod[33:17];
    end
    if (cmd.phase) begin
      cap <= sts.capture;
      lvl <= 16'((17'd1 << cur_bits) - 17'd1);
    end
    for (int i = 0; i < 2; i++) begin
      if (cmd.q_mul) begin
        qprod[i] <= 32'({~dry[i][15], dry[i][14:0]}) * 32'(lvl);
      end
      if (cmd.q_init) begin
        rem[i] <= {1'b0, num[i][31:17]};
        quo[i] <= num[i][16:0];
      end
      if (cmd.div_step) begin
        rem[i] <= dge[i] ? 16'(dtry[i] - {1'b0, lvl}) : dtry[i][15:0];
        quo[i] <= {quo[i][15:0], dge[i]};
      end
      if (cmd.mix1) begin
        pd[i] <= 34'($signed(dry[i])) * 34'($signed({1'b0, dw}));
        ph[i] <= 34'($signed(held[i])) * 34'($signed({1'b0, wet}));
      end
      if (cmd.mix2) begin
        blend[i] <= pd[i] + ph[i];
      end
      if (cmd.mix3) begin
        gprod[i] <= 51'(blend[i]) * 51'($signed({1'b0, gain}));
      end
    end
    if (cmd.out_load) begin
      m_tdata <= {res[1], res[0]};
    end
  end

endmodule

[hdl/stereo_bitcrusher_chaos_top.sv]
`timescale 1ns / 1ps
// Items are handled one at a time: a new item is accepted only in the idle state, once
// the last result has been loaded into the output register. On a capture the 17-step
// restoring divider (both channels in parallel) runs; without one it is skipped.
// The next item is accepted while a finished result waits in the output register.
// Reset (rst, synchronous): config to defaults, phase to one, held samples to zero.
// Top level: joins sbc_ctrl and sbc_dp. Depends on sbc_pkg.
module stereo_bitcrusher_chaos_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // left_in, right_in, left_acc, right_acc, entropy_level, prob_random,
  // bits_random, rate_random, zero pad
  input  logic [sbc_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                              s_tuser,   // block_start
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sbc_pkg::OUT_DATA_W-1:0]    m_tdata,   // left_out, right_out
  input  logic                              cfg_we,
  input  logic [sbc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [sbc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  sbc_pkg::cmd_t cmd;
  sbc_pkg::sts_t sts;

  sbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Testbench for stereo_bitcrusher_chaos_top: directed and random stereo items under
// random stalls, checked field by field by a bit-accurate scoreboard class.
// Depends on sbc_pkg and the top-level RTL.
module tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam int FIELD_BITS = 129;  // packed width of the input fields
  localparam longint SHALF = longint'(1) << (sbc_pkg::SAMPLE_W - 1);

  typedef struct {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic signed [15:0] left_acc;
    logic signed [15:0] right_acc;
    logic [16:0]        entropy;
    logic [15:0]        prob;
    logic [15:0]        bits_rnd;
    logic [15:0]        rate_rnd;
    logic               block_start;
  } crush_item_t;

  class crush_scoreboard;
    int max_bits, capture_rate, chaos_amount, gain_q12, wet_mix;
    int phase, cur_bits, cur_rate;
    longint held_l, held_r;
    logic [sbc_pkg::OUT_DATA_W-1:0] expected_q[$];
    int mismatches;

    function new();
      max_bits = int'(sbc_pkg::RST_MAX_BITS);
      capture_rate = int'(sbc_pkg::RST_RATE);
      chaos_amount = int'(sbc_pkg::RST_CHAOS);
      gain_q12 = int'(sbc_pkg::RST_GAIN);
      wet_mix = int'(sbc_pkg::RST_WET);
      phase = int'(sbc_pkg::RST_PHASE);
      cur_bits = int'(sbc_pkg::RST_MAX_BITS);
      cur_rate = int'(sbc_pkg::RST_RATE);
      held_l = 0;
      held_r = 0;
      mismatches = 0;
    endfunction

    function int clampi(longint v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return int'(v);
    endfunction

    function longint sat_sample(longint v);
      if (v > SHALF - 1) return SHALF - 1;
      if (v < -SHALF) return -SHALF;
      return v;
    endfunction

    function void write_reg(logic [sbc_pkg::CFG_ADDR_W-1:0] idx,
                            logic [sbc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        sbc_pkg::REG_MAX_BITS:
          max_bits = clampi(val[4:0], sbc_pkg::MIN_BITS, sbc_pkg::BITS_CEIL);
        sbc_pkg::REG_RATE:
          capture_rate = clampi(val, sbc_pkg::MIN_RATE, sbc_pkg::ONE_Q16);
        sbc_pkg::REG_CHAOS: chaos_amount = clampi(val, 0, sbc_pkg::ONE_Q16);
        sbc_pkg::REG_GAIN:  gain_q12 = int'(val[15:0]);
        sbc_pkg::REG_WET:   wet_mix = clampi(val, 0, sbc_pkg::ONE_Q16);
        default: ;
      endcase
    endfunction

    // round to 2^nbits levels (0 to 2^nbits-1) and back to full scale
    function longint crush(longint s, int nbits);
      longint lv, u, q, r;
      lv = (longint'(1) << nbits) - 1;
      u = s + SHALF;
      q = (u * lv + SHALF) >> sbc_pkg::SAMPLE_W;
      r = ((q << sbc_pkg::SAMPLE_W) + lv / 2) / lv;
      return sat_sample(r - SHALF);
    endfunction

    function longint blend_out(longint dry, longint held, longint acc);
      longint m, blend, scaled;
      m = wet_mix;
      blend = dry * (sbc_pkg::ONE_Q16 - m) + held * m;
      scaled = (blend * gain_q12 + (longint'(1) << 27)) >>> 28;
      return sat_sample(acc + scaled);
    endfunction

    function void take_input(crush_item_t it);
      longint one_minus, eff;
      logic [15:0] lo, ro;
      if (it.block_start) begin
        cur_bits = max_bits;
        cur_rate = capture_rate;
      end
      one_minus = (it.entropy >= sbc_pkg::ONE_Q16) ? 0 :
                  sbc_pkg::ONE_Q16 - longint'(it.entropy);
      eff = (longint'(chaos_amount) * one_minus) >> 17;
      if (longint'(it.prob) < eff) begin
        cur_bits = sbc_pkg::MIN_BITS +
                   int'((longint'(it.bits_rnd) * (max_bits - sbc_pkg::MIN_BITS + 1)) >> 16);
        cur_rate = sbc_pkg::MIN_RATE +
                   int'((longint'(it.rate_rnd) * (capture_rate - sbc_pkg::MIN_RATE)) >> 16);
      end
      phase += cur_rate;
      if (phase >= sbc_pkg::ONE_Q16) begin
        phase -= sbc_pkg::ONE_Q16;
        held_l = crush(it.left_in, cur_bits);
        held_r = crush(it.right_in, cur_bits);
      end
      if (it.left_in == 0) held_l = 0;
      if (it.right_in == 0) held_r = 0;
      lo = 16'(blend_out(it.left_in, held_l, it.left_acc));
      ro = 16'(blend_out(it.right_in, held_r, it.right_acc));
      expected_q.push_back({ro, lo});
    endfunction

    function void note_mismatch(string field, logic [15:0] want, logic [15:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("tb: mismatch %s expected %0d actual %0d", field,
                 $signed(want), $signed(got));
    endfunction

    function void check_output(logic [sbc_pkg::OUT_DATA_W-1:0] got);
      logic [sbc_pkg::OUT_DATA_W-1:0] want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: unexpected result %h", got);
        return;
      end
      want = expected_q.pop_front();
      if (got[15:0] !== want[15:0]) note_mismatch("left_out", want[15:0], got[15:0]);
      if (got[31:16] !== want[31:16]) note_mismatch("right_out", want[31:16], got[31:16]);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [sbc_pkg::IN_DATA_W-1:0]    s_tdata = '0;
  logic                             s_tuser = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [sbc_pkg::OUT_DATA_W-1:0]   m_tdata;
  logic                             cfg_we = 1'b0;
  logic [sbc_pkg::CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [sbc_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

  crush_scoreboard sb;
  int tx_idle_pct = 10;
  int rx_idle_pct = 10;
  int rx_hold_req = 0;
  int cycles = 0;

  stereo_bitcrusher_chaos_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    int hold_left;
    if (rx_hold_req > 0) begin
      hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_output(m_tdata);
  end

  function automatic logic [sbc_pkg::IN_DATA_W-1:0] pack_item(crush_item_t it);
    return {{(sbc_pkg::IN_DATA_W - FIELD_BITS){1'b0}}, it.rate_rnd, it.bits_rnd, it.prob,
            it.entropy, it.right_acc, it.left_acc, it.right_in, it.left_in};
  endfunction

  function automatic crush_item_t mk(logic [15:0] ln, logic [15:0] rn, logic [15:0] la,
                                     logic [15:0] ra, logic [16:0] ent, logic [15:0] pr,
                                     logic [15:0] br, logic [15:0] rr, logic bs);
    crush_item_t it;
    it.left_in = ln;
    it.right_in = rn;
    it.left_acc = la;
    it.right_acc = ra;
    it.entropy = ent;
    it.prob = pr;
    it.bits_rnd = br;
    it.rate_rnd = rr;
    it.block_start = bs;
    return it;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic crush_item_t rand_item(bit force_start);
    logic [16:0] ent;
    logic [15:0] pr;
    case ($urandom_range(9))
      0: ent = 17'd0;
      1: ent = 17'(sbc_pkg::ONE_Q16);
      2: ent = 17'($urandom);
      default: ent = 17'($urandom_range(sbc_pkg::ONE_Q16));
    endcase
    pr = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(4095));
    return mk(rand_sample(), rand_sample(), rand_sample(), rand_sample(), ent, pr,
              16'($urandom), 16'($urandom), force_start || ($urandom_range(9) == 0));
  endfunction

  task automatic send_item(crush_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pack_item(it);
    s_tuser <= it.block_start;
    do @(posedge clk); while (!s_tready);
    sb.take_input(it);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [sbc_pkg::CFG_ADDR_W-1:0] idx,
                           logic [sbc_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic cfg_end();
    cfg_we <= 1'b0;
  endtask

  task automatic rand_config();
    logic [sbc_pkg::CFG_DATA_W-1:0] v;
    cfg_write(sbc_pkg::REG_MAX_BITS, 17'($urandom_range(31)));
    case ($urandom_range(4))
      0: v = '0;
      1: v = 17'(sbc_pkg::ONE_Q16);
      2: v = '1;
      3: v = 17'($urandom_range(sbc_pkg::MIN_RATE, 2048));
      default: v = 17'($urandom);
    endcase
    cfg_write(sbc_pkg::REG_RATE, v);
    case ($urandom_range(3))
      0: v = '0;
      1: v = 17'(sbc_pkg::ONE_Q16);
      2: v = 17'($urandom);
      default: v = 17'($urandom_range(sbc_pkg::ONE_Q16));
    endcase
    cfg_write(sbc_pkg::REG_CHAOS, v);
    case ($urandom_range(4))
      0: v = '0;
      1: v = 17'h0ffff;
      2: v = 17'(sbc_pkg::RST_GAIN);
      3: v = 17'($urandom_range(8192));
      default: v = 17'($urandom_range(65535));
    endcase
    cfg_write(sbc_pkg::REG_GAIN, v);
    case ($urandom_range(3))
      0: v = '0;
      1: v = 17'(sbc_pkg::ONE_Q16);
      2: v = 17'($urandom);
      default: v = 17'($urandom_range(sbc_pkg::ONE_Q16));
    endcase
    cfg_write(sbc_pkg::REG_WET, v);
    cfg_end();
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // defaults: first item captures, extremes, saturation, zero dry
    send_item(mk(16'h8000, 16'h7fff, 16'h0000, 16'h0000, 17'd0, 16'hffff, 16'h0, 16'h0,
                 1'b0));
    send_item(mk(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 17'd0, 16'hffff, 16'h0, 16'h0,
                 1'b0));
    send_item(mk(16'h0000, 16'h0000, 16'h1234, 16'hedcc, 17'd0, 16'h0, 16'h0, 16'h0, 1'b0));
    send_item(mk(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 17'h1ffff, 16'h0, 16'hffff,
                 16'hffff, 1'b1));
    send_item(mk(16'h0001, 16'hffff, 16'h0000, 16'h0000, 17'd0, 16'h0, 16'h0, 16'h0, 1'b0));
    drain();

    // out-of-range writes clamp high; full chaos
    cfg_write(sbc_pkg::REG_MAX_BITS, 17'h1f);
    cfg_write(sbc_pkg::REG_RATE, 17'h1ffff);
    cfg_write(sbc_pkg::REG_CHAOS, 17'h1ffff);
    cfg_write(sbc_pkg::REG_GAIN, 17'hffff);
    cfg_write(sbc_pkg::REG_WET, 17'h1ffff);
    cfg_end();
    send_item(mk(16'h7fff, 16'h8000, 16'h0000, 16'h0000, 17'd0, 16'h0, 16'h0, 16'h0, 1'b1));
    send_item(mk(16'h4000, 16'hc000, 16'h0000, 16'h0000, 17'd0, 16'h0, 16'hffff,
                 16'hffff, 1'b0));
    send_item(mk(16'h0123, 16'hfedc, 16'h0000, 16'h0000, 17'(sbc_pkg::ONE_Q16), 16'h0,
                 16'h0, 16'h0, 1'b1));
    send_item(mk(16'h1000, 16'hf000, 16'h0000, 16'h0000, 17'd0, 16'h7fff, 16'h8000,
                 16'h8000, 1'b0));
    send_item(mk(16'h0800, 16'hf800, 16'h0000, 16'h0000, 17'd0, 16'h8000, 16'h0, 16'h0,
                 1'b0));
    send_item(mk(16'h0000, 16'h0100, 16'h0000, 16'h0000, 17'd0, 16'hffff, 16'h0, 16'h0,
                 1'b0));
    drain();

    // clamp low, zero gain and mix; unknown indexes ignored
    cfg_write(sbc_pkg::REG_MAX_BITS, '0);
    cfg_write(sbc_pkg::REG_RATE, '0);
    cfg_write(sbc_pkg::REG_CHAOS, '0);
    cfg_write(sbc_pkg::REG_GAIN, '0);
    cfg_write(sbc_pkg::REG_WET, '0);
    for (int a = sbc_pkg::REG_WET + 1; a < (1 << sbc_pkg::CFG_ADDR_W); a++)
      cfg_write(a[sbc_pkg::CFG_ADDR_W-1:0], '1);
    cfg_end();
    send_item(mk(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 17'd0, 16'h0, 16'h0, 16'h0, 1'b1));
    send_item(mk(16'h1234, 16'h4321, 16'h0042, 16'hff00, 17'd0, 16'h0, 16'h0, 16'h0, 1'b0));
    drain();

    // one-bit depth, capture on every item, fully wet
    cfg_write(sbc_pkg::REG_MAX_BITS, 17'd1);
    cfg_write(sbc_pkg::REG_RATE, 17'(sbc_pkg::ONE_Q16));
    cfg_write(sbc_pkg::REG_GAIN, 17'(sbc_pkg::RST_GAIN));
    cfg_write(sbc_pkg::REG_WET, 17'(sbc_pkg::ONE_Q16));
    cfg_end();
    send_item(mk(16'h7fff, 16'h8000, 16'h0000, 16'h0000, 17'd0, 16'h0, 16'h0, 16'h0, 1'b1));
    send_item(mk(16'h0001, 16'hffff, 16'h0000, 16'h0000, 17'd0, 16'h0, 16'h0, 16'h0, 1'b0));
    send_item(mk(16'h3fff, 16'hc001, 16'h7000, 16'h9000, 17'd0, 16'h0, 16'h0, 16'h0, 1'b0));

    for (int p = 0; p < 8; p++) begin
      drain();
      rand_config();
      tx_idle_pct = (p == 2) ? 0 : 10;
      rx_idle_pct = (p == 2) ? 0 : 10;
      for (int i = 0; i < 50; i++) begin
        if (p == 4 && i == 5) rx_hold_req = 300;
        if (p == 5 && i == 25) drain();
        send_item(rand_item(i == 0));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/sbc_pkg.sv
hdl/sbc_ctrl.sv
hdl/sbc_dp.sv
hdl/stereo_bitcrusher_chaos_top.sv
dv/tb.sv
